[design/shfp_pkg.sv]
// ----------------------------------------------------------------------------
// shfp_pkg
// Constants shared by the sync-header frame parser: sync pattern, frame
// kinds, frame lengths and the default frame size.
// ----------------------------------------------------------------------------
package shfp_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 26;
   localparam int HEADER_BYTES            = 5;

   // Payload bytes held in registers; the last byte of a frame comes straight
   // from the input, so only the bytes before it are kept.
   localparam int STORED_BYTES_MAX = 20;

   localparam logic [31:0] SYNC_WORD = 32'hFF00_FF00;

   localparam logic [1:0] KIND_SENSOR = 2'd1;
   localparam logic [1:0] KIND_SHORT  = 2'd2;

   localparam int BYTE_INDEX_WIDTH = 5;

   // Index of the last payload byte for each kind
   localparam logic [BYTE_INDEX_WIDTH-1:0] LAST_SENSOR = 5'd20;
   localparam logic [BYTE_INDEX_WIDTH-1:0] LAST_SHORT  = 5'd2;

endpackage

[design/sync_header_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// sync_header_frame_parser_core
// Hunts a byte stream for the sync pattern FF 00 FF 00, takes the type byte
// after it and collects the frame payload, then presents one decoded
// transaction per complete frame.
// ----------------------------------------------------------------------------
//
//   channel   ports                         direction  carries
//   req       req_valid, req_stall, req_*   in         one received byte
//   rsp       rsp_valid, rsp_stall, rsp_*   out        one decoded frame
//
// One byte is taken per clock unless held off; a decoded frame appears in the
// cycle after its last byte is accepted and sits in the result register until taken.
// Bytes that cannot finish a frame are taken even while a result waits; only
// the last byte of a frame is held off while rsp_stall holds an older result.
// Reset (synchronous) clears the hunting history and returns to hunting; the
// payload store is not cleared, every byte read being written by its frame.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_core #(
   parameter int MAX_FRAME_BYTES = shfp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_msg_type,
   output logic [31:0]        rsp_time_word,
   output logic [7:0]         rsp_touch_byte,
   output logic [39:0]        rsp_limit_bytes,
   output logic signed [15:0] rsp_accel_x,
   output logic signed [15:0] rsp_accel_y,
   output logic signed [15:0] rsp_accel_z,
   output logic [31:0]        rsp_debug_word,
   output logic [7:0]         rsp_check_byte
);

   localparam int PAYLOAD_SLOTS = MAX_FRAME_BYTES - shfp_pkg::HEADER_BYTES;
   localparam int STORE_DEPTH   = (PAYLOAD_SLOTS < shfp_pkg::STORED_BYTES_MAX) ?
                                  PAYLOAD_SLOTS : shfp_pkg::STORED_BYTES_MAX;
   localparam bit CHECK_KEPT    = (PAYLOAD_SLOTS > shfp_pkg::STORED_BYTES_MAX);
   localparam int IW            = shfp_pkg::BYTE_INDEX_WIDTH;

   logic [31:0]   history_ff, history_in;
   logic          in_frame_ff, in_frame_in;
   logic [1:0]    kind_ff, kind_in;
   logic [IW-1:0] byte_index_ff, byte_index_in;
   logic [7:0]    store_ff [STORE_DEPTH];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    type_ff;
   logic [31:0]   time_ff;
   logic [7:0]    touch_ff;
   logic [39:0]   limit_ff;
   logic [15:0]   ax_ff, ay_ff, az_ff;
   logic [31:0]   debug_ff;
   logic [7:0]    check_ff;

   logic          accept;
   logic          frame_last;
   logic          emit;
   logic          sync_seen;
   logic          kind_ok;
   logic [7:0]    pb [shfp_pkg::STORED_BYTES_MAX];

   // Payload bytes beyond the store read as zero
   for (genvar i = 0; i < shfp_pkg::STORED_BYTES_MAX; i++) begin : g_pb
      if (i < STORE_DEPTH) begin : g_kept
         assign pb[i] = store_ff[i];
      end else begin : g_lost
         assign pb[i] = 8'h00;
      end
   end

   assign frame_last = in_frame_ff &&
                       (((kind_ff == shfp_pkg::KIND_SENSOR) &&
                         (byte_index_ff == shfp_pkg::LAST_SENSOR)) ||
                        ((kind_ff == shfp_pkg::KIND_SHORT) &&
                         (byte_index_ff == shfp_pkg::LAST_SHORT)));

   // Hold off only a byte that would overwrite a result still waiting
   assign req_stall = rsp_valid_ff && rsp_stall && frame_last;
   assign accept    = req_valid && !req_stall;
   assign emit      = accept && frame_last;

   assign sync_seen = (history_ff == shfp_pkg::SYNC_WORD);
   assign kind_ok   = (req_rx_byte[7:2] == 6'd0) &&
                      ((req_rx_byte[1:0] == shfp_pkg::KIND_SENSOR) ||
                       (req_rx_byte[1:0] == shfp_pkg::KIND_SHORT));

   always_comb begin
      history_in    = history_ff;
      in_frame_in   = in_frame_ff;
      kind_in       = kind_ff;
      byte_index_in = byte_index_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            history_in = {history_ff[23:0], req_rx_byte};
            if (sync_seen && kind_ok) begin
               in_frame_in   = 1'b1;
               kind_in       = req_rx_byte[1:0];
               byte_index_in = '0;
            end
         end else if (frame_last) begin
            in_frame_in   = 1'b0;
            byte_index_in = '0;
         end else begin
            byte_index_in = byte_index_ff + IW'(1);
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff    <= '0;
         in_frame_ff   <= 1'b0;
         kind_ff       <= '0;
         byte_index_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         history_ff    <= history_in;
         in_frame_ff   <= in_frame_in;
         kind_ff       <= kind_in;
         byte_index_ff <= byte_index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (accept && in_frame_ff && (byte_index_ff == IW'(i))) begin
            store_ff[i] <= req_rx_byte;
         end
      end
   end

   // Decode the frame on its last byte; short messages carry only the check
   always_ff @(posedge clock) begin
      if (emit) begin
         type_ff <= kind_ff;
         if (kind_ff == shfp_pkg::KIND_SENSOR) begin
            time_ff  <= {pb[3], pb[2], pb[1], pb[0]};
            touch_ff <= pb[4];
            limit_ff <= {pb[9], pb[8], pb[7], pb[6], pb[5]};
            ax_ff    <= {pb[11], pb[10]};
            ay_ff    <= {pb[13], pb[12]};
            az_ff    <= {pb[15], pb[14]};
            debug_ff <= {pb[19], pb[18], pb[17], pb[16]};
            check_ff <= CHECK_KEPT ? req_rx_byte : 8'h00;
         end else begin
            time_ff  <= '0;
            touch_ff <= '0;
            limit_ff <= '0;
            ax_ff    <= '0;
            ay_ff    <= '0;
            az_ff    <= '0;
            debug_ff <= '0;
            check_ff <= req_rx_byte;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_msg_type    = type_ff;
   assign rsp_time_word   = time_ff;
   assign rsp_touch_byte  = touch_ff;
   assign rsp_limit_bytes = limit_ff;
   assign rsp_accel_x     = ax_ff;
   assign rsp_accel_y     = ay_ff;
   assign rsp_accel_z     = az_ff;
   assign rsp_debug_word  = debug_ff;
   assign rsp_check_byte  = check_ff;

`ifndef SYNTHESIS
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (kind_ff == shfp_pkg::KIND_SENSOR) ||
                      (kind_ff == shfp_pkg::KIND_SHORT))
      else $error("frame open with unknown kind");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff && (kind_ff == shfp_pkg::KIND_SHORT) |->
         byte_index_ff <= shfp_pkg::LAST_SHORT)
      else $error("short frame index overran");

   a_index_bound_sensor: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> byte_index_ff <= shfp_pkg::LAST_SENSOR)
      else $error("sensor frame index overran");

   a_result_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_frame_ff) && !in_frame_ff)
      else $error("result without a closing frame");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(check_ff) &&
                                    $stable(type_ff))
      else $error("waiting result overwritten");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for sync_header_frame_parser_core. Serial bytes go in on the req
// channel and decoded frames come back on the rsp channel, with random idle
// cycles and back-pressure on both sides. A frame tracker follows the hunting
// history and the payload bytes and predicts each decoded frame, which it
// compares field by field with what the block presents.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAYLOAD_SLOTS = shfp_pkg::MAX_FRAME_BYTES_DEFAULT -
                                  shfp_pkg::HEADER_BYTES;
   localparam int RANDOM_BYTES  = 1100;

   typedef struct packed {
      logic [1:0]         msg_type;
      logic [31:0]        time_word;
      logic [7:0]         touch_byte;
      logic [39:0]        limit_bytes;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        debug_word;
      logic [7:0]         check_byte;
   } frame_type;

   class frame_tracker_type;
      logic [31:0] history;
      logic        in_frame;
      logic [1:0]  kind;
      logic [4:0]  byte_index;
      logic [7:0]  payload [PAYLOAD_SLOTS];
      frame_type   frames_due [$];
      int          errors;

      function new();
         history    = '0;
         in_frame   = 1'b0;
         kind       = '0;
         byte_index = '0;
         errors     = 0;
         foreach (payload[i]) payload[i] = '0;
      endfunction

      // Follow one accepted byte; queue a decoded frame when one completes
      function void take_byte(logic [7:0] b);
         logic       sync_seen;
         logic [4:0] frame_len;
         frame_type  f;
         if (!in_frame) begin
            sync_seen = (history == shfp_pkg::SYNC_WORD);
            history   = {history[23:0], b};
            if (sync_seen && (b == {6'd0, shfp_pkg::KIND_SENSOR} ||
                              b == {6'd0, shfp_pkg::KIND_SHORT})) begin
               in_frame   = 1'b1;
               kind       = b[1:0];
               byte_index = '0;
            end
            return;
         end
         if (byte_index < PAYLOAD_SLOTS)
            payload[byte_index] = b;
         byte_index = byte_index + 5'd1;
         frame_len  = (kind == shfp_pkg::KIND_SENSOR) ? shfp_pkg::LAST_SENSOR + 5'd1 :
                                                        shfp_pkg::LAST_SHORT + 5'd1;
         if (byte_index < frame_len)
            return;
         in_frame   = 1'b0;
         byte_index = '0;
         f          = '0;
         f.msg_type = kind;
         if (kind == shfp_pkg::KIND_SENSOR) begin
            f.time_word   = {payload[3], payload[2], payload[1], payload[0]};
            f.touch_byte  = payload[4];
            f.limit_bytes = {payload[9], payload[8], payload[7], payload[6], payload[5]};
            f.accel_x     = {payload[11], payload[10]};
            f.accel_y     = {payload[13], payload[12]};
            f.accel_z     = {payload[15], payload[14]};
            f.debug_word  = {payload[19], payload[18], payload[17], payload[16]};
            f.check_byte  = payload[20];
         end else begin
            f.check_byte  = payload[2];
         end
         frames_due = {frames_due, f};
      endfunction

      function void compare_field(string name, logic [39:0] want, logic [39:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void match_frame(frame_type got);
         frame_type want;
         if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame, expected none, got %h", $time, got);
            return;
         end
         want = frames_due.pop_front();
         compare_field("msg_type",    want.msg_type,    got.msg_type);
         compare_field("time_word",   want.time_word,   got.time_word);
         compare_field("touch_byte",  want.touch_byte,  got.touch_byte);
         compare_field("limit_bytes", want.limit_bytes, got.limit_bytes);
         compare_field("accel_x",     want.accel_x,     got.accel_x);
         compare_field("accel_y",     want.accel_y,     got.accel_y);
         compare_field("accel_z",     want.accel_z,     got.accel_z);
         compare_field("debug_word",  want.debug_word,  got.debug_word);
         compare_field("check_byte",  want.check_byte,  got.check_byte);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_msg_type;
   logic [31:0]        rsp_time_word;
   logic [7:0]         rsp_touch_byte;
   logic [39:0]        rsp_limit_bytes;
   logic signed [15:0] rsp_accel_x;
   logic signed [15:0] rsp_accel_y;
   logic signed [15:0] rsp_accel_z;
   logic [31:0]        rsp_debug_word;
   logic [7:0]         rsp_check_byte;

   frame_tracker_type tracker = new();
   int                bytes_sent = 0;
   logic              quiet = 1'b0;

   sync_header_frame_parser_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_msg_type    (rsp_msg_type),
      .rsp_time_word   (rsp_time_word),
      .rsp_touch_byte  (rsp_touch_byte),
      .rsp_limit_bytes (rsp_limit_bytes),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_accel_y     (rsp_accel_y),
      .rsp_accel_z     (rsp_accel_z),
      .rsp_debug_word  (rsp_debug_word),
      .rsp_check_byte  (rsp_check_byte)
   );

   always #5 clock = ~clock;

   // Present one byte and hold it until the transaction is taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_sync();
      for (int i = 0; i < 4; i++)
         send_byte(shfp_pkg::SYNC_WORD[31 - 8 * i -: 8]);
   endtask

   function automatic logic [7:0] pick_byte(int bias);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < bias / 2)
         return 8'hFF;
      else if (sel < bias)
         return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_frame(input logic [1:0] k);
      int len;
      len = (k == shfp_pkg::KIND_SENSOR) ? int'(shfp_pkg::LAST_SENSOR) + 1 :
                                           int'(shfp_pkg::LAST_SHORT) + 1;
      send_sync();
      send_byte({6'd0, k});
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(12));
   endtask

   // Result side: stall for a drawn number of cycles, then take the next frame
   initial begin : rsp_side
      int n;
      wait (!reset);
      forever begin
         @(negedge clock);
         n = quiet ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.match_frame(frame_type'{rsp_msg_type, rsp_time_word, rsp_touch_byte,
                                         rsp_limit_bytes, rsp_accel_x, rsp_accel_y,
                                         rsp_accel_z, rsp_debug_word, rsp_check_byte});
      end
   end

   initial begin : stimulus
      int          sel;
      int          n;
      logic [7:0]  t;
      logic [7:0]  sensor_bytes [21];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Overlapping sync: the FF after the first pattern is an unknown type
      // and is dropped, yet it completes a second pattern with the next 00
      foreach (sensor_bytes[i]) sensor_bytes[i] = 8'h00;
      send_sync();
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte({6'd0, shfp_pkg::KIND_SHORT});
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);

      // Sensor report with extreme values in the touch, accel_x, accel_y and debug fields
      sensor_bytes = '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF,
                       8'h01, 8'h00, 8'hFF, 8'h00, 8'h01,
                       8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_sync();
      send_byte({6'd0, shfp_pkg::KIND_SENSOR});
      foreach (sensor_bytes[i]) send_byte(sensor_bytes[i]);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 9) == 0);
         sel   = $urandom_range(0, 99);
         if (sel < 70) begin
            send_frame($urandom_range(0, 1) ? shfp_pkg::KIND_SENSOR : shfp_pkg::KIND_SHORT);
         end else if (sel < 80) begin
            // sync followed by a type that is neither kind
            do t = 8'($urandom_range(0, 255));
            while (t == {6'd0, shfp_pkg::KIND_SENSOR} || t == {6'd0, shfp_pkg::KIND_SHORT});
            send_sync();
            send_byte(t);
         end else if (sel < 90) begin
            // broken header: part of the pattern, then anything
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_byte(shfp_pkg::SYNC_WORD[31 - 8 * i -: 8]);
            send_byte(pick_byte(30));
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               send_byte(pick_byte(60));
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;

      n = 0;
      while (tracker.frames_due.size() != 0 && n < 10000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.frames_due.size() == 0) begin
         $display("sync_header_frame_parser_core verification clean");
      end else begin
         $display("sync_header_frame_parser_core verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("sync_header_frame_parser_core verification failed");
      $finish;
   end

endmodule
